// ----- design/dtw_template_classifier_top_defines.svh -----
// assertion macros for the template classifier
`ifndef DTW_TEMPLATE_CLASSIFIER_TOP_DEFINES_SVH
`define DTW_TEMPLATE_CLASSIFIER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define DTWC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DTWC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DTWC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define DTWC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- design/dtwc_pkg.sv -----
// shared types and constants of the template classifier
`default_nettype none

package dtwc_pkg;

    localparam int COST_W   = 32;
    localparam int COORD_W  = 8;
    localparam int SQ_W     = 16;
    localparam int TAG_W    = 8;
    localparam int PS_MAX_W = 13;

    localparam logic [COST_W-1:0] COST_INF = {COST_W{1'b1}};

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              hold;
        logic [TAG_W-1:0]  tag;
        logic [COST_W-1:0] new_cost;
        logic [COST_W-1:0] old_cost;
    } link_t;

endpackage

`default_nettype wire

// ----- design/dtwc_cell.sv -----
// one warping cell: one column of every template row, three register stages
`default_nettype none

module dtwc_cell #(
    parameter int NUM_TEMPLATES = 32,
    parameter int TW            = 5
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                first_cell,
    input  wire logic                                fresh,
    input  wire logic signed [dtwc_pkg::COORD_W-1:0] xs,
    input  wire logic signed [dtwc_pkg::COORD_W-1:0] ys,
    input  wire logic                                pt_we,
    input  wire logic [TW-1:0]                       pt_addr,
    input  wire logic signed [dtwc_pkg::COORD_W-1:0] pt_x,
    input  wire logic signed [dtwc_pkg::COORD_W-1:0] pt_y,
    input  wire dtwc_pkg::link_t                     link_in,
    output dtwc_pkg::link_t                          link_out
);

    logic [dtwc_pkg::COST_W-1:0]         slot_mem [NUM_TEMPLATES];
    logic signed [dtwc_pkg::COORD_W-1:0] px_mem [NUM_TEMPLATES];
    logic signed [dtwc_pkg::COORD_W-1:0] py_mem [NUM_TEMPLATES];

    dtwc_pkg::link_t                     s1_reg;
    dtwc_pkg::link_t                     s2_reg;
    dtwc_pkg::link_t                     out_reg;
    logic [dtwc_pkg::COST_W-1:0]         slot_rd_reg;
    logic signed [dtwc_pkg::COORD_W-1:0] px_rd_reg;
    logic signed [dtwc_pkg::COORD_W-1:0] py_rd_reg;
    logic [dtwc_pkg::COST_W-1:0]         old_s2_reg;
    logic [dtwc_pkg::SQ_W-1:0]           dx2_reg;
    logic [dtwc_pkg::SQ_W-1:0]           dy2_reg;

    logic [dtwc_pkg::COST_W-1:0] old_m;
    logic [dtwc_pkg::COST_W-1:0] min_a;
    logic [dtwc_pkg::COST_W-1:0] min3;
    logic signed [8:0]           dx;
    logic signed [8:0]           dy;
    logic signed [17:0]          dx2_full;
    logic signed [17:0]          dy2_full;
    logic [dtwc_pkg::COST_W:0]   sum;
    logic [dtwc_pkg::COST_W-1:0] new_val;
    dtwc_pkg::link_t             s2_next;
    dtwc_pkg::link_t             out_next;

    // stage 1: memory reads
    always_ff @(posedge aclk) begin
        slot_rd_reg <= slot_mem[link_in.tag[TW-1:0]];
        px_rd_reg   <= px_mem[link_in.tag[TW-1:0]];
        py_rd_reg   <= py_mem[link_in.tag[TW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (pt_we) begin
            px_mem[pt_addr] <= pt_x;
            py_mem[pt_addr] <= pt_y;
        end
    end

    // stage 2: squares and neighbor minimum
    always_comb begin
        if (fresh) begin
            old_m = first_cell ? '0 : dtwc_pkg::COST_INF;
        end else begin
            old_m = slot_rd_reg;
        end
        dx       = 9'(xs) - 9'(px_rd_reg);
        dy       = 9'(ys) - 9'(py_rd_reg);
        dx2_full = dx * dx;
        dy2_full = dy * dy;
        min_a    = (s1_reg.new_cost < s1_reg.old_cost) ? s1_reg.new_cost : s1_reg.old_cost;
        min3     = (old_m < min_a) ? old_m : min_a;
        s2_next          = s1_reg;
        s2_next.new_cost = min3;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg <= '0;
            s2_reg <= '0;
        end else begin
            s1_reg <= link_in;
            s2_reg <= s2_next;
        end
    end

    always_ff @(posedge aclk) begin
        old_s2_reg <= old_m;
        dx2_reg    <= dx2_full[dtwc_pkg::SQ_W-1:0];
        dy2_reg    <= dy2_full[dtwc_pkg::SQ_W-1:0];
    end

    // stage 3: saturating accumulate, or shift the row by one on hold or in the first cell
    always_comb begin
        sum = {1'b0, s2_reg.new_cost} + 33'(dx2_reg) + 33'(dy2_reg);
        if (s2_reg.hold || first_cell) begin
            new_val = s2_reg.old_cost;
        end else if (sum[dtwc_pkg::COST_W]) begin
            new_val = dtwc_pkg::COST_INF;
        end else begin
            new_val = sum[dtwc_pkg::COST_W-1:0];
        end
        out_next          = s2_reg;
        out_next.new_cost = new_val;
        out_next.old_cost = old_s2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg <= '0;
        end else begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_reg.valid) begin
            slot_mem[s2_reg.tag[TW-1:0]] <= new_val;
        end
    end

    assign link_out = out_reg;

endmodule

`default_nettype wire

// ----- design/dtwc_div.sv -----
// restoring divider, one quotient bit per cycle
`default_nettype none

module dtwc_div #(
    parameter int DW = 9
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [dtwc_pkg::COST_W-1:0] dividend,
    input  wire logic [DW-1:0]               divisor,
    output logic                             done,
    output logic [dtwc_pkg::COST_W-1:0]      quotient
);

    logic [DW-1:0]               rem_reg;
    logic [DW-1:0]               dvs_reg;
    logic [dtwc_pkg::COST_W-1:0] quo_reg;
    logic [5:0]                  cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [DW:0]                 trial;
    logic                        fits;

    always_comb begin
        trial = {rem_reg, quo_reg[dtwc_pkg::COST_W-1]};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(dtwc_pkg::COST_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= fits ? DW'(trial - {1'b0, dvs_reg}) : trial[DW-1:0];
            quo_reg <= {quo_reg[dtwc_pkg::COST_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- design/dtw_template_classifier_top.sv -----
// nearest-template classifier by dynamic time warping over a chain of cells
//
//  channel  | direction | handshake           | word
//  s_       | in        | s_valid / s_ready   | load point or sample point
//  m_       | out       | m_valid / m_ready   | best template, distances, length
//  cfg_     | in        | cfg_valid/cfg_ready | active template count
//
// a load word is written into the cell point memories when it is accepted
// in a sample word one template enters the cell chain per cycle
// and each of the TEMPLATE_LEN+1 cells has three stages
// a last sample word then runs the one-bit-per-cycle divider and loads
// the output register
// reset is synchronous; the first point of a sample restarts every row, no clearing pass
// s_ready is low while a sample word is in the chain, the divider or the push; m_ready stalls only the final push
`default_nettype none
`include "dtw_template_classifier_top_defines.svh"

module dtw_template_classifier_top #(
    parameter int NUM_TEMPLATES  = 32,
    parameter int TEMPLATE_LEN   = 32,
    parameter int MAX_SAMPLE_LEN = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_opcode,
    input  wire logic [4:0]  s_template_index,
    input  wire logic [4:0]  s_point_index,
    input  wire logic signed [7:0] s_x_coord,
    input  wire logic signed [7:0] s_y_coord,
    input  wire logic        s_last_point,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [4:0]       m_best_template,
    output logic [31:0]      m_total_distance,
    output logic [31:0]      m_mean_distance,
    output logic [8:0]       m_sample_length,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [5:0]  cfg_wdata
);

    localparam int TW    = (NUM_TEMPLATES > 1) ? $clog2(NUM_TEMPLATES) : 1;
    localparam int NCELL = TEMPLATE_LEN + 1;
    localparam int PSW   = $clog2(MAX_SAMPLE_LEN + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_PUSH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [5:0]                          active_reg;
    logic [8:0]                          nact_reg, nact_next;
    logic [8:0]                          act_ext;
    logic signed [dtwc_pkg::COORD_W-1:0] xs_reg;
    logic signed [dtwc_pkg::COORD_W-1:0] ys_reg;
    logic                                last_reg;
    logic                                fresh_reg;
    logic [PSW-1:0]                      points_reg;
    logic [8:0]                          issue_reg;
    logic [dtwc_pkg::COST_W-1:0]         slot0_mem [NUM_TEMPLATES];
    logic [dtwc_pkg::COST_W-1:0]         slot0_rd_reg;
    logic                                head_v_reg;
    logic [dtwc_pkg::TAG_W-1:0]          head_tag_reg;
    logic [dtwc_pkg::COST_W-1:0]         best_dist_reg, best_dist_next;
    logic [TW-1:0]                       best_reg, best_next;
    logic                                m_valid_reg;
    logic [4:0]                          m_best_reg;
    logic [31:0]                         m_total_reg;
    logic [31:0]                         m_mean_reg;
    logic [8:0]                          m_len_reg;

    dtwc_pkg::link_t             chain [NCELL+1];
    dtwc_pkg::link_t             tail;
    logic [dtwc_pkg::COST_W-1:0] head_old;
    logic                        accept;
    logic                        load_we;
    logic [8:0]                  tidx_ext;
    logic [8:0]                  pidx_ext;
    logic                        issue;
    logic                        tail_final;
    logic                        div_done;
    logic [dtwc_pkg::COST_W-1:0] div_quo;
    logic [dtwc_pkg::PS_MAX_W-1:0] ps_ext;
    logic                        push;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign tidx_ext  = 9'(s_template_index);
    assign pidx_ext  = 9'(s_point_index);
    assign load_we   = accept && (s_opcode == dtwc_pkg::OP_LOAD)
                       && (tidx_ext < 9'(NUM_TEMPLATES)) && (pidx_ext < 9'(TEMPLATE_LEN));

    always_comb begin
        act_ext = 9'(active_reg);
        if (act_ext == 9'd0) begin
            nact_next = 9'd1;
        end else if (act_ext > 9'(NUM_TEMPLATES)) begin
            nact_next = 9'(NUM_TEMPLATES);
        end else begin
            nact_next = act_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 6'd32;
        end else if (cfg_valid && cfg_ready) begin
            active_reg <= cfg_wdata;
        end
    end

    // head: column zero of every row lives here
    assign issue = (state_reg == ST_RUN) && (issue_reg < 9'(NUM_TEMPLATES));

    always_ff @(posedge aclk) begin
        if (issue) begin
            slot0_rd_reg <= slot0_mem[issue_reg[TW-1:0]];
        end
        head_tag_reg <= issue_reg[dtwc_pkg::TAG_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_v_reg <= 1'b0;
        end else begin
            head_v_reg <= issue;
        end
    end

    assign head_old = fresh_reg ? dtwc_pkg::COST_INF : slot0_rd_reg;

    always_comb begin
        chain[0].valid    = head_v_reg;
        chain[0].hold     = ({1'b0, head_tag_reg} >= nact_reg);
        chain[0].tag      = head_tag_reg;
        chain[0].new_cost = head_old;
        chain[0].old_cost = head_old;
    end

    for (genvar g = 1; g <= NCELL; g++) begin : g_cell
        dtwc_cell #(
            .NUM_TEMPLATES (NUM_TEMPLATES),
            .TW            (TW)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .first_cell (g == 1),
            .fresh      (fresh_reg),
            .xs         (xs_reg),
            .ys         (ys_reg),
            .pt_we      (load_we && (g >= 2) && ((pidx_ext + 9'd2) == 9'(g))),
            .pt_addr    (tidx_ext[TW-1:0]),
            .pt_x       (s_x_coord),
            .pt_y       (s_y_coord),
            .link_in    (chain[g-1]),
            .link_out   (chain[g])
        );
    end

    // tail: wrap the marker back into column zero and track the best template
    assign tail       = chain[NCELL];
    assign tail_final = tail.valid && ({1'b0, tail.tag} == 9'(NUM_TEMPLATES - 1));

    always_ff @(posedge aclk) begin
        if (tail.valid) begin
            slot0_mem[tail.tag[TW-1:0]] <= tail.hold ? tail.old_cost : dtwc_pkg::COST_INF;
        end
    end

    always_comb begin
        best_dist_next = best_dist_reg;
        best_next      = best_reg;
        if (accept) begin
            best_dist_next = dtwc_pkg::COST_INF;
            best_next      = '0;
        end else if (tail.valid && last_reg && !tail.hold && (tail.new_cost < best_dist_reg)) begin
            best_dist_next = tail.new_cost;
            best_next      = tail.tag[TW-1:0];
        end
    end

    dtwc_div #(
        .DW (PSW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    ((state_reg == ST_RUN) && tail_final && last_reg),
        .dividend (best_dist_next),
        .divisor  (points_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign push = (state_reg == ST_PUSH) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_opcode == dtwc_pkg::OP_SAMPLE)) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (tail_final) begin
                    state_next = last_reg ? ST_DIV : ST_IDLE;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (push) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            points_reg <= '0;
            issue_reg  <= '0;
            fresh_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept && (s_opcode == dtwc_pkg::OP_SAMPLE)) begin
                fresh_reg <= (points_reg == '0);
                issue_reg <= '0;
                if (points_reg < PSW'(MAX_SAMPLE_LEN)) begin
                    points_reg <= points_reg + PSW'(1);
                end
            end else begin
                if (issue) begin
                    issue_reg <= issue_reg + 9'd1;
                end
                if (push) begin
                    points_reg <= '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        best_dist_reg <= best_dist_next;
        best_reg      <= best_next;
        if (accept && (s_opcode == dtwc_pkg::OP_SAMPLE)) begin
            xs_reg   <= s_x_coord;
            ys_reg   <= s_y_coord;
            last_reg <= s_last_point;
            nact_reg <= nact_next;
        end
    end

    // output register
    assign ps_ext = dtwc_pkg::PS_MAX_W'(points_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            m_best_reg  <= 5'(best_reg);
            m_total_reg <= best_dist_reg;
            m_mean_reg  <= div_quo;
            m_len_reg   <= ps_ext[8:0];
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_best_template  = m_best_reg;
    assign m_total_distance = m_total_reg;
    assign m_mean_distance  = m_mean_reg;
    assign m_sample_length  = m_len_reg;

    `DTWC_ASSERT_IMP(a_tail_tag_range, aclk, aresetn, tail.valid, {1'b0, tail.tag} < 9'(NUM_TEMPLATES))
    `DTWC_ASSERT_IMP(a_tail_in_run, aclk, aresetn, tail.valid, state_reg == ST_RUN)
    `DTWC_ASSERT_IMP(a_div_done_in_div, aclk, aresetn, div_done, state_reg == ST_DIV)
    `DTWC_ASSERT_NXT(a_push_sets_valid, aclk, aresetn, push, m_valid)

endmodule

`default_nettype wire

// ----- tb/tb_dtw_template_classifier_top.sv -----
// testbench for the template classifier: load and sample words against a warping-cost predictor
`timescale 1ns / 1ps
`default_nettype none

typedef struct {
    logic [4:0]  best;
    logic [31:0] total;
    logic [31:0] mean;
    logic [8:0]  length;
} match_t;

class dtw_score;
    localparam int NT = 32;
    localparam int TL = 32;
    localparam int DL = TL + 2;
    localparam int MAXLEN = 256;

    logic signed [7:0] pt_x[NT*TL];
    logic signed [7:0] pt_y[NT*TL];
    logic [31:0] row_cost[NT][DL];
    int unsigned seen;
    int unsigned phase;
    logic [5:0] active;
    match_t pending_q[$];
    int errors;
    int results;

    function new();
        foreach (row_cost[t, j]) row_cost[t][j] = dtwc_pkg::COST_INF;
        seen = 0;
        phase = 0;
        active = 6'd32;
        errors = 0;
        results = 0;
    endfunction

    function logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? dtwc_pkg::COST_INF : s[31:0];
    endfunction

    function void set_active(logic [5:0] v);
        active = v;
    endfunction

    function void note_word(logic op, logic [4:0] ti, logic [4:0] pi,
                            logic signed [7:0] x, logic signed [7:0] y, logic last);
        int nact, k, dx, dy, r;
        logic [31:0] c, lo, best_d;
        logic [4:0] best_t;
        match_t m;
        k = 0;
        best_d = dtwc_pkg::COST_INF;
        best_t = '0;
        if (op == dtwc_pkg::OP_LOAD) begin
            pt_x[ti*TL + pi] = x;
            pt_y[ti*TL + pi] = y;
            return;
        end
        nact = active;
        if (nact == 0) nact = 1;
        if (nact > NT) nact = NT;
        if (seen == 0) begin
            for (int t = 0; t < NT; t++) begin
                for (int j = 0; j < DL; j++) row_cost[t][j] = dtwc_pkg::COST_INF;
                row_cost[t][1] = '0;
            end
            phase = 0;
        end
        r = (phase + 1) % DL;
        if (seen < MAXLEN) seen++;
        for (int t = 0; t < nact; t++) begin
            for (int j = 1; j <= TL; j++) begin
                dx = int'(x) - int'(pt_x[t*TL + j - 1]);
                dy = int'(y) - int'(pt_y[t*TL + j - 1]);
                c = dx*dx + dy*dy;
                k = (j + 1 + DL - r) % DL;
                lo = row_cost[t][(k+1)%DL];
                if (row_cost[t][(k+DL-1)%DL] < lo) lo = row_cost[t][(k+DL-1)%DL];
                if (row_cost[t][k] < lo) lo = row_cost[t][k];
                row_cost[t][k] = sat_sum(c, lo);
            end
            row_cost[t][(k+1)%DL] = dtwc_pkg::COST_INF;
            if (last && row_cost[t][k] < best_d) begin
                best_d = row_cost[t][k];
                best_t = t[4:0];
            end
        end
        phase = r;
        if (!last) return;
        m.best = best_t;
        m.total = best_d;
        m.mean = best_d / seen;
        m.length = seen[8:0];
        pending_q.push_back(m);
        seen = 0;
        phase = 0;
    endfunction

    function void check_result(logic [4:0] b, logic [31:0] tot, logic [31:0] mn,
                               logic [8:0] len);
        match_t e;
        results++;
        if (pending_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result best %0d total %0d", b, tot);
            return;
        end
        e = pending_q.pop_front();
        if (b !== e.best || tot !== e.total || mn !== e.mean || len !== e.length) begin
            errors++;
            if (errors <= 10)
                $display("mismatch exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                         e.best, e.total, e.mean, e.length, b, tot, mn, len);
        end
    endfunction
endclass

module tb_dtw_template_classifier_top;
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_opcode = dtwc_pkg::OP_LOAD;
    logic [4:0] s_template_index = '0;
    logic [4:0] s_point_index = '0;
    logic signed [7:0] s_x_coord = '0;
    logic signed [7:0] s_y_coord = '0;
    logic s_last_point = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [4:0] m_best_template;
    logic [31:0] m_total_distance;
    logic [31:0] m_mean_distance;
    logic [8:0] m_sample_length;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [5:0] cfg_wdata = '0;

    dtw_score sb = new();
    int words_in = 0;
    int cfg_done = 0;
    int burst_left = 0;
    int loaded = 0;
    int samples = 0;
    int stall_mode = 0;
    int stall_cnt = 0;

    dtw_template_classifier_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_template_index(s_template_index), .s_point_index(s_point_index),
        .s_x_coord(s_x_coord), .s_y_coord(s_y_coord), .s_last_point(s_last_point),
        .m_valid(m_valid), .m_ready(m_ready), .m_best_template(m_best_template),
        .m_total_distance(m_total_distance), .m_mean_distance(m_mean_distance),
        .m_sample_length(m_sample_length),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("tb: failure");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.note_word(s_opcode, s_template_index, s_point_index,
                         s_x_coord, s_y_coord, s_last_point);
            words_in++;
        end
        if (aresetn && cfg_valid && cfg_ready) begin
            sb.set_active(cfg_wdata);
            cfg_done++;
        end
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_best_template, m_total_distance, m_mean_distance,
                            m_sample_length);
    end

    // receiver stall pattern, the mode is redrawn at random from four patterns
    always @(negedge aclk) begin
        stall_cnt++;
        if (stall_cnt % 300 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ((stall_cnt / 7) % 2 == 0);
            default: m_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    function logic signed [7:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 8'sh80;
            1: return 8'sh7f;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_word(logic op, logic [4:0] ti, logic [4:0] pi,
                             logic signed [7:0] x, logic signed [7:0] y, logic last);
        int prev_words;
        prev_words = words_in;
        s_valid <= 1'b1;
        s_opcode <= op;
        s_template_index <= ti;
        s_point_index <= pi;
        s_x_coord <= x;
        s_y_coord <= y;
        s_last_point <= last;
        do @(negedge aclk); while (words_in == prev_words);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 8);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    task automatic write_active(logic [5:0] v);
        int prev_cfg;
        drain();
        prev_cfg = cfg_done;
        cfg_valid <= 1'b1;
        cfg_wdata <= v;
        do @(negedge aclk); while (cfg_done == prev_cfg);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_templates(int upto);
        for (int t = loaded; t < upto; t++)
            for (int p = 0; p < 32; p++)
                if (t == 1) send_word(dtwc_pkg::OP_LOAD, 5'(t), 5'(p), sb.pt_x[p], sb.pt_y[p],
                                      1'($urandom_range(0, 1)));
                else send_word(dtwc_pkg::OP_LOAD, 5'(t), 5'(p), rand_coord(), rand_coord(),
                               1'($urandom_range(0, 1)));
        if (upto > loaded) loaded = upto;
    endtask

    task automatic send_sample(int len);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_word(dtwc_pkg::OP_LOAD, 5'($urandom_range(0, loaded - 1)),
                          5'($urandom_range(0, 31)), rand_coord(), rand_coord(),
                          1'($urandom_range(0, 1)));
            send_word(dtwc_pkg::OP_SAMPLE, 5'($urandom), 5'($urandom), rand_coord(),
                      rand_coord(), i == len - 1);
        end
        samples++;
    endtask

    task automatic random_samples(int n);
        for (int i = 0; i < n; i++)
            send_sample(($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6));
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        write_active(6'd1);
        load_templates(1);
        send_word(dtwc_pkg::OP_SAMPLE, 5'd0, 5'd0, 8'sh7f, 8'sh7f, 1'b1);
        send_word(dtwc_pkg::OP_SAMPLE, 5'd31, 5'd31, 8'sh80, 8'sh80, 1'b1);
        send_word(dtwc_pkg::OP_SAMPLE, 5'd0, 5'd0, 8'sh80, 8'sh7f, 1'b0);
        send_word(dtwc_pkg::OP_SAMPLE, 5'd0, 5'd0, 8'sh7f, 8'sh80, 1'b0);
        send_word(dtwc_pkg::OP_SAMPLE, 5'd0, 5'd0, 8'sh00, 8'sh00, 1'b1);
        samples += 3;
        load_templates(8);
        write_active(6'd8);
        random_samples(12);
        send_sample(262);
        write_active(6'd0);
        random_samples(8);
        write_active(6'd5);
        random_samples(5);
        drain();
        $display("covered %0d words, %0d samples, %0d results, template counts 1 to 8",
                 words_in, samples, sb.results);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

`default_nettype wire
